@@ rtl/spectrometer_frame_readout_top_macros.svh @@
// Assertion helpers used by the readout sequencer RTL.
`ifndef SPECTROMETER_FRAME_READOUT_TOP_MACROS_SVH
`define SPECTROMETER_FRAME_READOUT_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr same-cycle check failed");

// Next-cycle implication.
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr next-cycle check failed");

`endif

@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps
package sfr_pkg;

   localparam int unsigned AdcW   = 12;
   localparam int unsigned IndexW = 9;
   localparam int unsigned TickW  = 16;

   // csr register indexes
   localparam logic [1:0] CSR_CLOCK_HIGH_TICKS = 2'd0;
   localparam logic [1:0] CSR_START_CLOCKS     = 2'd1;
   localparam logic [1:0] CSR_LEAD_CLOCKS      = 2'd2;
   localparam logic [1:0] CSR_REJECT_THRESHOLD = 2'd3;

   // reset values
   localparam logic [15:0] RST_CLOCK_HIGH_TICKS = 16'd1;
   localparam logic [7:0]  RST_START_CLOCKS     = 8'd6;
   localparam logic [7:0]  RST_LEAD_CLOCKS      = 8'd87;
   localparam logic [11:0] RST_REJECT_THRESHOLD = 12'd2500;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_START = 4'b0010,
      PH_LEAD  = 4'b0100,
      PH_PIXEL = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TickW-1:0] clock_high_ticks;
      logic [7:0]       start_clocks;
      logic [7:0]       lead_clocks;
      logic [AdcW-1:0]  reject_threshold;
   } cfg_type;

   typedef struct packed {
      logic              sensor_clk;
      logic              start_pulse;
      logic              busy_res;
      logic              pixel_valid;
      logic [IndexW-1:0] pixel_index;
      logic [AdcW-1:0]   pixel_value;
      logic              frame_last;
      logic [AdcW-1:0]   frame_max;
   } result_type;

endpackage

@@ rtl/sfr_seq.sv @@
`timescale 1ns / 1ps
`include "spectrometer_frame_readout_top_macros.svh"
module sfr_seq
   import sfr_pkg::*;
#(
   parameter int unsigned PIXELS   = 288,
   parameter int unsigned ADC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                start_request,
   input  logic [AdcW-1:0]     adc_sample,
   input  cfg_type             cfg,
   output result_type          res
);

   localparam int unsigned    AdcUsed = (ADC_BITS < AdcW) ? ADC_BITS : AdcW;
   localparam logic [AdcW-1:0] AdcMask = AdcW'((64'd1 << AdcUsed) - 64'd1);
   localparam logic [IndexW-1:0] PixelsLim = IndexW'(PIXELS);

   phase_type         phase_ff, phase_in, cur_phase;
   logic [TickW-1:0]  tick_ff, tick_in, cur_tick;
   logic [IndexW-1:0] count_ff, count_in, cur_count;
   logic [AdcW-1:0]   max_ff, max_in, cur_max;

   logic [TickW-1:0]  high_len;
   logic [AdcW-1:0]   adc_m, pix_val, new_max;
   logic [IndexW-1:0] next_count;
   logic              low_tick;

   // a start seen while idle restarts the frame on this very tick
   always_comb begin
      if (phase_ff == PH_IDLE && start_request) begin
         cur_phase = PH_START;
         cur_tick  = '0;
         cur_count = '0;
         cur_max   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_tick  = tick_ff;
         cur_count = count_ff;
         cur_max   = max_ff;
      end
   end

   assign high_len   = (cfg.clock_high_ticks == '0) ? TickW'(1) : cfg.clock_high_ticks;
   assign low_tick   = cur_tick >= high_len;
   assign next_count = cur_count + IndexW'(1);
   assign adc_m      = adc_sample & AdcMask;
   assign pix_val    = (adc_m > cfg.reject_threshold) ? '0 : adc_m;
   assign new_max    = (pix_val > cur_max) ? pix_val : cur_max;

   always_comb begin
      res      = '0;
      phase_in = cur_phase;
      tick_in  = cur_tick;
      count_in = cur_count;
      max_in   = cur_max;
      if (cur_phase != PH_IDLE) begin
         res.busy_res    = 1'b1;
         res.sensor_clk  = ~low_tick;
         res.start_pulse = (cur_phase == PH_START);
         if (!low_tick) begin
            tick_in = cur_tick + TickW'(1);
         end else begin
            tick_in = '0;
            case (cur_phase)
               PH_START: begin
                  if (next_count >= {1'b0, cfg.start_clocks}) begin
                     count_in = '0;
                     phase_in = (cfg.lead_clocks == '0) ? PH_PIXEL : PH_LEAD;
                  end else begin
                     count_in = next_count;
                  end
               end
               PH_LEAD: begin
                  if (next_count >= {1'b0, cfg.lead_clocks}) begin
                     count_in = '0;
                     phase_in = PH_PIXEL;
                  end else begin
                     count_in = next_count;
                  end
               end
               PH_PIXEL: begin
                  res.pixel_valid = 1'b1;
                  res.pixel_index = cur_count;
                  res.pixel_value = pix_val;
                  if (next_count >= PixelsLim || next_count == '0) begin
                     res.frame_last = 1'b1;
                     res.frame_max  = new_max;
                     phase_in       = PH_IDLE;
                     count_in       = '0;
                     max_in         = '0;
                  end else begin
                     count_in = next_count;
                     max_in   = new_max;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         count_ff <= '0;
         max_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         count_ff <= count_in;
         max_ff   <= max_in;
      end
   end

   `SFR_ASSERT_NOW(a_last_in_pixel, clock, reset, step && res.frame_last, res.pixel_valid && res.busy_res && !res.sensor_clk)
   `SFR_ASSERT_NOW(a_index_range, clock, reset, step && res.pixel_valid, res.pixel_index < PixelsLim || PixelsLim == '0)
   `SFR_ASSERT_NOW(a_value_reject, clock, reset, step && res.pixel_valid, res.pixel_value <= cfg.reject_threshold)
   `SFR_ASSERT_NEXT(a_idle_after_last, clock, reset, step && res.frame_last, phase_ff == PH_IDLE && max_ff == '0)

endmodule

@@ rtl/spectrometer_frame_readout_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Payload
// req_      in   req_tvalid / req_tready    tick: start request, adc sample
// rsp_      out  rsp_tvalid / rsp_tready    pin levels, pixel, frame max; tlast
// csr_      in   csr_we (no wait)           csr_index, csr_wdata
//
// Path: a request is held in the input register, then its result lands in
// the output register when the sequencer steps.
// Throughput: one request per cycle unless rsp_tready stalls; the sequencer
// step is one short compare and increment between the two registers.
// Reset: synchronous, active high; sequencer idle, registers at defaults.
// Stalls: rsp_tready low holds the result; the input register still takes one
// more request, after which req_tready drops until the output drains.
module spectrometer_frame_readout_top
   import sfr_pkg::*;
#(
   parameter int unsigned PIXELS   = 288,
   parameter int unsigned ADC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] start_request, [12:1] adc_sample, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] sensor_clk, [1] start_pulse, [2] busy_res,
                                    // [3] pixel_valid, [12:4] pixel_index,
                                    // [24:13] pixel_value, [36:25] frame_max, rest zero
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_high_ticks <= RST_CLOCK_HIGH_TICKS;
         cfg_ff.start_clocks     <= RST_START_CLOCKS;
         cfg_ff.lead_clocks      <= RST_LEAD_CLOCKS;
         cfg_ff.reject_threshold <= RST_REJECT_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_HIGH_TICKS: cfg_ff.clock_high_ticks <= csr_wdata;
            CSR_START_CLOCKS:     cfg_ff.start_clocks     <= csr_wdata[7:0];
            CSR_LEAD_CLOCKS:      cfg_ff.lead_clocks      <= csr_wdata[7:0];
            CSR_REJECT_THRESHOLD: cfg_ff.reject_threshold <= csr_wdata[AdcW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic            in_valid_ff;
   logic            start_ff;
   logic [AdcW-1:0] adc_ff;

   // output register
   logic       out_valid_ff;
   result_type out_ff;
   result_type step_res;

   logic step;

   // step the sequencer whenever a held request has somewhere to go
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         start_ff <= req_tdata[0];
         adc_ff   <= req_tdata[AdcW:1];
      end
   end

   sfr_seq #(
      .PIXELS   (PIXELS),
      .ADC_BITS (ADC_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .start_request (start_ff),
      .adc_sample    (adc_ff),
      .cfg           (cfg_ff),
      .res           (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.frame_last;
   assign rsp_tdata  = {3'b000,
                        out_ff.frame_max,
                        out_ff.pixel_value,
                        out_ff.pixel_index,
                        out_ff.pixel_valid,
                        out_ff.busy_res,
                        out_ff.start_pulse,
                        out_ff.sensor_clk};

endmodule

@@ bench/sfr_tick_checker.sv @@
`timescale 1ns / 1ps
module sfr_tick_checker
   import sfr_pkg::*;
#(
   parameter int unsigned PIXELS   = 288,
   parameter int unsigned ADC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int unsigned fail_count,
   output int unsigned pending_results,
   output int unsigned frames_seen,
   output int unsigned pixels_seen
);

   cfg_type           cfg;
   phase_type         phase;
   logic [TickW-1:0]  tick_count;
   logic [IndexW-1:0] clock_count;
   logic [AdcW-1:0]   running_max;
   result_type        expected_ticks[$];
   int unsigned       n_fail, n_frames, n_pixels, n_results;

   // one sequencer tick: pin levels plus any pixel taken on a low tick
   task automatic advance_sequencer(input logic start, input logic [AdcW-1:0] adc,
                                    output result_type r);
      logic [TickW-1:0]  hi;
      logic [IndexW-1:0] next_count;
      logic [AdcW-1:0]   sample, kept, peak;
      r = '0;
      hi = (cfg.clock_high_ticks == '0) ? TickW'(1) : cfg.clock_high_ticks;
      sample = adc & AdcW'((1 << ADC_BITS) - 1);
      if (phase == PH_IDLE && start) begin
         phase = PH_START;
         tick_count = '0;
         clock_count = '0;
         running_max = '0;
      end
      if (phase != PH_IDLE) begin
         r.busy_res = 1'b1;
         r.start_pulse = (phase == PH_START);
         if (tick_count < hi) begin
            r.sensor_clk = 1'b1;
            tick_count = tick_count + 1'b1;
         end else begin
            tick_count = '0;
            next_count = clock_count + 1'b1;
            case (phase)
               PH_START: begin
                  if (next_count >= cfg.start_clocks) begin
                     clock_count = '0;
                     phase = (cfg.lead_clocks == '0) ? PH_PIXEL : PH_LEAD;
                  end else begin
                     clock_count = next_count;
                  end
               end
               PH_LEAD: begin
                  if (next_count >= cfg.lead_clocks) begin
                     clock_count = '0;
                     phase = PH_PIXEL;
                  end else begin
                     clock_count = next_count;
                  end
               end
               default: begin
                  kept = (sample > cfg.reject_threshold) ? '0 : sample;
                  peak = (kept > running_max) ? kept : running_max;
                  r.pixel_valid = 1'b1;
                  r.pixel_index = clock_count;
                  r.pixel_value = kept;
                  if (next_count >= PIXELS || next_count == '0) begin
                     r.frame_last = 1'b1;
                     r.frame_max = peak;
                     phase = PH_IDLE;
                     clock_count = '0;
                     running_max = '0;
                  end else begin
                     clock_count = next_count;
                     running_max = peak;
                  end
               end
            endcase
         end
      end
   endtask

   function automatic string describe(result_type r);
      return $sformatf("clk=%0b st=%0b busy=%0b pv=%0b idx=%0d val=%0d last=%0b max=%0d",
                       r.sensor_clk, r.start_pulse, r.busy_res, r.pixel_valid,
                       r.pixel_index, r.pixel_value, r.frame_last, r.frame_max);
   endfunction

   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         cfg.clock_high_ticks = RST_CLOCK_HIGH_TICKS;
         cfg.start_clocks = RST_START_CLOCKS;
         cfg.lead_clocks = RST_LEAD_CLOCKS;
         cfg.reject_threshold = RST_REJECT_THRESHOLD;
         phase = PH_IDLE;
         tick_count = '0;
         clock_count = '0;
         running_max = '0;
         expected_ticks.delete();
         n_fail = 0;
         n_frames = 0;
         n_pixels = 0;
         n_results = 0;
      end else begin
         // drain side first so a stray response never consumes a fresh expectation
         if (rsp_tvalid && rsp_tready) begin
            got.sensor_clk = rsp_tdata[0];
            got.start_pulse = rsp_tdata[1];
            got.busy_res = rsp_tdata[2];
            got.pixel_valid = rsp_tdata[3];
            got.pixel_index = rsp_tdata[12:4];
            got.pixel_value = rsp_tdata[24:13];
            got.frame_max = rsp_tdata[36:25];
            got.frame_last = rsp_tlast;
            n_pixels += got.pixel_valid;
            n_frames += got.frame_last;
            if (expected_ticks.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("result %0d arrived with nothing expected: %s",
                           n_results, describe(got));
            end else begin
               want = expected_ticks.pop_front();
               if (got != want) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("result %0d differs\n  expected %s\n  actual   %s",
                              n_results, describe(want), describe(got));
               end
            end
            n_results++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CLOCK_HIGH_TICKS: cfg.clock_high_ticks = csr_wdata;
               CSR_START_CLOCKS:     cfg.start_clocks = csr_wdata[7:0];
               CSR_LEAD_CLOCKS:      cfg.lead_clocks = csr_wdata[7:0];
               CSR_REJECT_THRESHOLD: cfg.reject_threshold = csr_wdata[AdcW-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_sequencer(req_tdata[0], req_tdata[12:1], want);
            expected_ticks.push_back(want);
         end
      end
      fail_count <= n_fail;
      pending_results <= expected_ticks.size();
      frames_seen <= n_frames;
      pixels_seen <= n_pixels;
   end

endmodule

@@ bench/spectrometer_frame_readout_top_tb.sv @@
`timescale 1ns / 1ps
module spectrometer_frame_readout_top_tb;
   import sfr_pkg::*;

   localparam int unsigned PIXELS       = 288;
   localparam int unsigned ADC_BITS     = 12;
   localparam int unsigned RANDOM_TICKS = 1650;
   // idling stops here so the tail runs at full rate
   localparam int unsigned QUIET_FROM   = 1350;
   // cycles with no handshake on either channel before giving up
   localparam int unsigned STALL_LIMIT  = 2000;

   // directed samples; with one-tick clocks and no lead the pixel samples land
   // on odd requests: full scale, at threshold, one above, one below, zero, ...
   localparam logic [11:0] DIRECTED_ADC [20] = '{
      12'd0,    12'd4095, 12'd4095, 12'd4095, 12'd0,
      12'd2000, 12'd4095, 12'd2001, 12'd0,    12'd1999,
      12'd4095, 12'd0,    12'd0,    12'd4095, 12'd2048,
      12'd1,    12'd0,    12'd1365, 12'd4095, 12'd2730
   };
   localparam logic [11:0] DIRECTED_THRESHOLD = 12'd2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [0] start_request, [12:1] adc_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;        // [0] sensor_clk, [1] start_pulse, [2] busy_res,
                                  // [3] pixel_valid, [12:4] pixel_index,
                                  // [24:13] pixel_value, [36:25] frame_max
   logic        rsp_tlast;        // frame_last
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int unsigned fail_count, pending_results, frames_seen, pixels_seen;

   // idling on both sides is on while this is set
   bit          idle_on = 1'b0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   always #5 clock = ~clock;

   spectrometer_frame_readout_top #(
      .PIXELS   (PIXELS),
      .ADC_BITS (ADC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sfr_tick_checker #(
      .PIXELS   (PIXELS),
      .ADC_BITS (ADC_BITS)
   ) i_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .frames_seen     (frames_seen),
      .pixels_seen     (pixels_seen)
   );

   // receiver back-pressure: random bursts with rsp_tready held low
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1)
            rsp_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 10);
      end
   end

   // watchdog: any handshake on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("spectrometer_frame_readout_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request; optional idle burst first, valid stays high between requests
   task automatic send_tick(input logic start, input logic [11:0] adc);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, adc, start};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait for every outstanding result plus pipeline slack
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned run_len;
      int unsigned start_mode;
      int unsigned settings;
      logic        start;
      logic [11:0] adc;
      logic [15:0] cur_high;
      logic [11:0] cur_threshold;
      int          near;

      sent = 0;
      settings = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: high time zero (acts as one), start clocks zero (still one
      // clock), no lead clocks, threshold edges; repeated starts while busy
      write_reg(CSR_CLOCK_HIGH_TICKS, 16'd0);
      write_reg(CSR_START_CLOCKS, 16'd0);
      write_reg(CSR_LEAD_CLOCKS, 16'd0);
      write_reg(CSR_REJECT_THRESHOLD, 16'(DIRECTED_THRESHOLD));
      csr_we <= 1'b0;
      cur_high = 16'd0;
      cur_threshold = DIRECTED_THRESHOLD;
      for (int i = 0; i < 20; i++)
         send_tick(i == 0 || i % 4 == 2, DIRECTED_ADC[i]);

      // random phases; each starts only once the pipe is empty, so register
      // changes land mid-frame at arbitrary sequencer positions
      while (sent < RANDOM_TICKS) begin
         wait_drained();
         idle_on = (sent < QUIET_FROM) && $urandom_range(0, 2) != 0;

         if (cur_high > 16'd4 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 19))
               0:       cur_high = 16'd0;
               1:       cur_high = 16'hFFFF;
               2:       cur_high = 16'($urandom_range(5, 40));
               3, 4, 5: cur_high = 16'($urandom_range(2, 4));
               default: cur_high = 16'd1;
            endcase
            write_reg(CSR_CLOCK_HIGH_TICKS, cur_high);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       write_reg(CSR_START_CLOCKS, 16'd0);
               1:       write_reg(CSR_START_CLOCKS, 16'd255);
               2:       write_reg(CSR_START_CLOCKS, 16'($urandom_range(1, 5)));
               default: write_reg(CSR_START_CLOCKS, 16'($urandom_range(6, 10)));
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0, 1:    write_reg(CSR_LEAD_CLOCKS, 16'd0);
               2:       write_reg(CSR_LEAD_CLOCKS, 16'd255);
               3:       write_reg(CSR_LEAD_CLOCKS, 16'd87);
               default: write_reg(CSR_LEAD_CLOCKS, 16'($urandom_range(1, 8)));
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       cur_threshold = 12'd0;
               1:       cur_threshold = 12'd4095;
               default: cur_threshold = 12'($urandom_range(0, 4095));
            endcase
            write_reg(CSR_REJECT_THRESHOLD, 16'(cur_threshold));
         end
         csr_we <= 1'b0;
         settings++;

         // start pattern for this phase: held high (back-to-back frames and a
         // start on the last pixel tick), frequent, rare, or none
         start_mode = $urandom_range(0, 3);
         run_len = $urandom_range(80, 250);
         // last phase is trimmed so the total lands on the request budget
         if (run_len > RANDOM_TICKS - sent)
            run_len = RANDOM_TICKS - sent;
         repeat (run_len) begin
            case (start_mode)
               0:       start = 1'b1;
               1:       start = ($urandom_range(0, 3) == 0);
               2:       start = ($urandom_range(0, 19) == 0);
               default: start = 1'b0;
            endcase
            case ($urandom_range(0, 7))
               0: adc = 12'd0;
               1: adc = 12'd4095;
               2, 3: begin
                  // hug the reject threshold
                  near = int'(cur_threshold) + $urandom_range(0, 4) - 2;
                  adc = (near < 0) ? 12'd0 : (near > 4095) ? 12'd4095 : 12'(near);
               end
               default: adc = 12'($urandom_range(0, 4095));
            endcase
            send_tick(start, adc);
            sent++;
         end
      end

      idle_on = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);

      $display("ran %0d directed and %0d random requests over %0d register settings",
               20, sent, settings);
      $display("saw %0d pixel samples in %0d completed frames", pixels_seen, frames_seen);
      if (fail_count == 0) begin
         $display("spectrometer_frame_readout_top: match");
      end else begin
         $display("%0d results differed", fail_count);
         $display("spectrometer_frame_readout_top: mismatch");
      end
      $finish;
   end

endmodule
